@@ rtl/ilt_pkg.sv @@
// ilt_pkg: shared types and constants for the irc line tokenizer
// parse phases, field kinds, character codes and the result record
// no dependencies
package ilt_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_NICK   = 3'd1,
    PH_HOST   = 3'd2,
    PH_CMD    = 3'd3,
    PH_PARAMS = 3'd4,
    PH_TRAIL  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_NICK  = 3'd1,
    K_HOST  = 3'd2,
    K_CMD   = 3'd3,
    K_PARAM = 3'd4,
    K_TRAIL = 3'd5
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic        saw_trailing;
    logic [3:0]  param_total;
    logic        bad_line;
    logic [3:0]  slot;
    kind_t       field_kind;
    logic [7:0]  out_byte;
  } result_t;

endpackage

@@ rtl/ilt_step.sv @@
// ilt_step: one parse step, current state and byte in, label and next state out
// purely combinational; sits between the input and result registers
// depends on ilt_pkg
module ilt_step import ilt_pkg::*; #(
  parameter int MAX_PARAMS = 15,
  parameter int SW = 4
) (
  input  logic [7:0]    byte_in,
  input  logic          start,
  input  phase_t        phase,
  input  logic [SW-1:0] slot_index,
  input  logic          slot0_nonempty,
  input  logic          trailing_seen,
  output result_t       res,
  output logic          line_done,
  output phase_t        phase_next,
  output logic [SW-1:0] slot_index_next,
  output logic          slot0_nonempty_next,
  output logic          trailing_seen_next
);

  localparam logic [SW:0] MAXP = (SW+1)'(MAX_PARAMS);

  always_comb begin
    phase_t        ph;
    logic [SW-1:0] si;
    logic          s0;
    logic          tr;
    logic          consumed;
    logic          is_end;
    logic          done;
    logic          bad;
    logic [7:0]    ob;
    kind_t         kind;
    logic [3:0]    slot;
    logic [SW:0]   total;

    ph       = start ? PH_START : phase;
    si       = start ? '0 : slot_index;
    s0       = start ? 1'b0 : slot0_nonempty;
    tr       = start ? 1'b0 : trailing_seen;
    consumed = 1'b0;
    done     = 1'b0;
    bad      = 1'b0;
    ob       = byte_in;
    kind     = K_NONE;
    slot     = 4'd0;
    is_end   = (byte_in == CH_CR) || (byte_in == CH_LF) || (byte_in == CH_NUL);

    // first byte: a colon opens the prefix and is swallowed
    if (ph == PH_START) begin
      if (byte_in == CH_COLON) begin
        ph       = PH_NICK;
        consumed = 1'b1;
      end else begin
        ph = PH_CMD;
      end
    end

    if (!consumed) begin
      case (ph)
        PH_NICK: begin
          if (byte_in == CH_NUL) begin
            bad = 1'b1;
            ph  = PH_DONE;
          end else if (byte_in == CH_BANG) begin
            ph = PH_HOST;
          end else if (byte_in == CH_SPACE) begin
            ph = PH_CMD;
          end else begin
            kind = K_NICK;
          end
        end
        PH_HOST: begin
          if (byte_in == CH_NUL) begin
            bad = 1'b1;
            ph  = PH_DONE;
          end else if (byte_in == CH_SPACE) begin
            ph = PH_CMD;
          end else begin
            kind = K_HOST;
          end
        end
        PH_CMD: begin
          if (byte_in == CH_NUL) begin
            bad = 1'b1;
            ph  = PH_DONE;
          end else if (byte_in == CH_SPACE) begin
            ph = PH_PARAMS;
            si = '0;
          end else begin
            kind = K_CMD;
            if (byte_in >= CH_LO_A && byte_in <= CH_LO_Z) begin
              ob = byte_in - CASE_OFS;
            end
          end
        end
        PH_PARAMS: begin
          if (is_end) begin
            done = 1'b1;
          end else if (byte_in == CH_COLON) begin
            // trailing takes over this slot, earlier bytes no longer count
            ph = PH_TRAIL;
            tr = 1'b1;
            if (si == '0) begin
              s0 = 1'b0;
            end
          end else if (byte_in == CH_SPACE) begin
            if (({1'b0, si} + (SW+1)'(1)) >= MAXP) begin
              bad = 1'b1;
              ph  = PH_DONE;
            end else begin
              si = si + SW'(1);
            end
          end else begin
            kind = K_PARAM;
            slot = 4'(si);
            if (si == '0) begin
              s0 = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (is_end) begin
            done = 1'b1;
          end else begin
            kind = K_TRAIL;
            slot = 4'(si);
            if (si == '0) begin
              s0 = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    total = {1'b0, si} + (SW+1)'(s0);
    if (done) begin
      ph = PH_DONE;
    end

    res.out_byte     = ob;
    res.field_kind   = kind;
    res.slot         = slot;
    res.bad_line     = bad;
    res.param_total  = done ? 4'(total) : 4'd0;
    res.saw_trailing = done ? tr : 1'b0;
    line_done        = done;

    phase_next          = ph;
    slot_index_next     = si;
    slot0_nonempty_next = s0;
    trailing_seen_next  = tr;
  end

endmodule

@@ rtl/irc_line_tokenizer.sv @@
// irc_line_tokenizer: byte-serial irc message tokenizer, top level
// input register, parse state, result register; uses ilt_step and ilt_pkg
//
//   channel  dir  bits   contents
//   s_*      in   8+1    tdata: in_byte; tuser: msg_start
//   m_*      out  24+1   tdata: result fields; tlast: line_done
//
// one item per cycle sustained while m_tready stays high; an accepted item passes
// through the input register, then the parse step into the result register
// synchronous reset returns the parser to start of message and empties both registers
// a stall on m_tready holds the result; one more item waits in the input register
module irc_line_tokenizer import ilt_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // msg_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [10:8] field_kind, [14:11] slot,
                                 // [15] bad_line, [19:16] param_total, [20] saw_trailing
  output logic        m_tlast    // line_done
);

  localparam int SW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_start;
  logic          adv;

  phase_t        phase, phase_next;
  logic [SW-1:0] slot_index, slot_index_next;
  logic          slot0_nonempty, slot0_nonempty_next;
  logic          trailing_seen, trailing_seen_next;

  result_t       res, res_q;
  logic          done, done_q;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  ilt_step #(.MAX_PARAMS(MAX_PARAMS), .SW(SW)) u_step (
    .byte_in             (in_byte),
    .start               (in_start),
    .phase               (phase),
    .slot_index          (slot_index),
    .slot0_nonempty      (slot0_nonempty),
    .trailing_seen       (trailing_seen),
    .res                 (res),
    .line_done           (done),
    .phase_next          (phase_next),
    .slot_index_next     (slot_index_next),
    .slot0_nonempty_next (slot0_nonempty_next),
    .trailing_seen_next  (trailing_seen_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      phase          <= PH_START;
      slot_index     <= '0;
      slot0_nonempty <= 1'b0;
      trailing_seen  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv) begin
        m_tvalid       <= 1'b1;
        phase          <= phase_next;
        slot_index     <= slot_index_next;
        slot0_nonempty <= slot0_nonempty_next;
        trailing_seen  <= trailing_seen_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
    if (adv) begin
      res_q  <= res;
      done_q <= done;
    end
  end

  assign m_tdata = {3'b000, res_q.saw_trailing, res_q.param_total, res_q.bad_line,
                    res_q.slot, res_q.field_kind, res_q.out_byte};
  assign m_tlast = done_q;

endmodule

@@ tb/irc_line_tokenizer_tb.sv @@
// irc_line_tokenizer_tb: self-checking bench for the irc line tokenizer
// predicts every labelled byte in a scoreboard class and drives random irc lines
// depends on ilt_pkg and irc_line_tokenizer
import ilt_pkg::*;

typedef struct {
  logic [7:0] out_byte;
  kind_t      field_kind;
  logic [3:0] slot;
  logic       line_done;
  logic       bad_line;
  logic [3:0] param_total;
  logic       saw_trailing;
} token_t;

class token_scoreboard;
  int max_params;
  phase_t ph;
  logic [3:0] slot_idx;
  logic slot0_used;
  logic trail_seen;
  token_t pending[$];
  int errors;

  function new(int max_p);
    max_params = max_p;
    errors = 0;
    restart();
  endfunction

  function void restart();
    ph = PH_START;
    slot_idx = '0;
    slot0_used = 1'b0;
    trail_seen = 1'b0;
  endfunction

  function bit is_line_end(logic [7:0] b);
    return b == CH_CR || b == CH_LF || b == CH_NUL;
  endfunction

  // label one accepted byte and queue the expected token
  function void note_input(logic [7:0] b, logic msg_start);
    token_t t;
    bit consumed;
    t.out_byte = b;
    t.field_kind = K_NONE;
    t.slot = '0;
    t.line_done = 1'b0;
    t.bad_line = 1'b0;
    t.param_total = '0;
    t.saw_trailing = 1'b0;
    consumed = 1'b0;
    if (msg_start) restart();
    if (ph == PH_START) begin
      if (b == CH_COLON) begin
        ph = PH_NICK;
        consumed = 1'b1;
      end else begin
        ph = PH_CMD;
      end
    end
    if (!consumed) begin
      case (ph)
        PH_NICK: begin
          if (b == CH_NUL) begin
            t.bad_line = 1'b1;
            ph = PH_DONE;
          end else if (b == CH_BANG) ph = PH_HOST;
          else if (b == CH_SPACE) ph = PH_CMD;
          else t.field_kind = K_NICK;
        end
        PH_HOST: begin
          if (b == CH_NUL) begin
            t.bad_line = 1'b1;
            ph = PH_DONE;
          end else if (b == CH_SPACE) ph = PH_CMD;
          else t.field_kind = K_HOST;
        end
        PH_CMD: begin
          if (b == CH_NUL) begin
            t.bad_line = 1'b1;
            ph = PH_DONE;
          end else if (b == CH_SPACE) begin
            ph = PH_PARAMS;
            slot_idx = '0;
          end else begin
            t.field_kind = K_CMD;
            if (b >= CH_LO_A && b <= CH_LO_Z) t.out_byte = b - CASE_OFS;
          end
        end
        PH_PARAMS: begin
          if (is_line_end(b)) t.line_done = 1'b1;
          else if (b == CH_COLON) begin
            // colon mid-parameter turns the rest of the slot into trailing
            ph = PH_TRAIL;
            trail_seen = 1'b1;
            if (slot_idx == 0) slot0_used = 1'b0;
          end else if (b == CH_SPACE) begin
            if (int'(slot_idx) + 1 >= max_params) begin
              t.bad_line = 1'b1;
              ph = PH_DONE;
            end else begin
              slot_idx = slot_idx + 1'b1;
            end
          end else begin
            t.field_kind = K_PARAM;
            t.slot = slot_idx;
            if (slot_idx == 0) slot0_used = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (is_line_end(b)) t.line_done = 1'b1;
          else begin
            t.field_kind = K_TRAIL;
            t.slot = slot_idx;
            if (slot_idx == 0) slot0_used = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (t.line_done) begin
      t.param_total = slot_idx + slot0_used;
      t.saw_trailing = trail_seen;
      ph = PH_DONE;
    end
    pending.push_back(t);
  endfunction

  function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [23:0] d, logic last);
    token_t t;
    if (pending.size() == 0) begin
      $error("result: unexpected item, tdata 0x%0h", d);
      errors++;
      return;
    end
    t = pending.pop_front();
    cmp_field("out_byte", t.out_byte, d[7:0]);
    cmp_field("field_kind", 8'(t.field_kind), 8'(d[10:8]));
    cmp_field("slot", 8'(t.slot), 8'(d[14:11]));
    cmp_field("bad_line", 8'(t.bad_line), 8'(d[15]));
    cmp_field("param_total", 8'(t.param_total), 8'(d[19:16]));
    cmp_field("saw_trailing", 8'(t.saw_trailing), 8'(d[20]));
    cmp_field("line_done", 8'(t.line_done), 8'(last));
  endfunction
endclass

module irc_line_tokenizer_tb;
  localparam int MAX_PARAMS = 15;
  localparam int RANDOM_BYTES = 1300;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  token_scoreboard sb;
  int burst_left;
  int bytes_sent;
  rx_mode_t rx_mode;
  int rx_left;
  int rx_cyc;

  irc_line_tokenizer #(.MAX_PARAMS(MAX_PARAMS)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("irc_line_tokenizer verification failed");
    $finish;
  end

  // receiver stall pattern, switching mode every so often
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_tready <= ((rx_cyc % 5) >= 2);
      default:     m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  task automatic send_byte(input logic [7:0] b, input logic msg_start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= msg_start;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, msg_start);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first && i == 0);
  endtask

  // mostly plain text, now and then any byte at all
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    b = 8'($urandom_range(8'h23, 8'h7e));
    if (b == CH_COLON) b = CH_LO_A;
    return b;
  endfunction

  function automatic logic [7:0] cmd_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h61, 8'h7a));
      1: return 8'($urandom_range(8'h41, 8'h5a));
      2: return 8'($urandom_range(8'h5b, 8'h7f));
      default: return text_byte();
    endcase
  endfunction

  task automatic send_line();
    logic [7:0] q[$];
    int n;
    int nparams;
    int cut;
    q.delete();
    if ($urandom_range(0, 1)) begin
      q.push_back(CH_COLON);
      n = $urandom_range(0, 4);
      repeat (n) q.push_back(text_byte());
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(CH_BANG);
        n = $urandom_range(0, 4);
        repeat (n) q.push_back(text_byte());
      end
      if ($urandom_range(0, 11) == 0) q.push_back(CH_NUL);
      q.push_back(CH_SPACE);
    end
    n = $urandom_range(0, 5);
    repeat (n) q.push_back(cmd_byte());
    if ($urandom_range(0, 11) == 0) q.push_back(CH_NUL);
    q.push_back(CH_SPACE);
    nparams = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 4);
    for (int i = 0; i < nparams; i++) begin
      if (i > 0) q.push_back(CH_SPACE);
      n = $urandom_range(0, 3);
      repeat (n) q.push_back(text_byte());
      if ($urandom_range(0, 9) == 0) q.push_back(CH_COLON);
    end
    if ($urandom_range(0, 1)) begin
      if (nparams > 0) q.push_back(CH_SPACE);
      q.push_back(CH_COLON);
      n = $urandom_range(0, 6);
      repeat (n) q.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE : text_byte());
    end
    case ($urandom_range(0, 2))
      0: q.push_back(CH_CR);
      1: q.push_back(CH_LF);
      default: q.push_back(CH_NUL);
    endcase
    // some lines get cut short by the next message start
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, q.size()) : q.size();
    for (int i = 0; i < cut; i++) send_byte(q[i], i == 0);
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    sb = new(MAX_PARAMS);
    burst_left = 0;
    bytes_sent = 0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    rx_cyc = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // prefix with host, command case bounds, colon inside a parameter
    send_text(":n!h az`{ p:t", 1'b1);
    send_byte(CH_CR, 1'b0);
    // high byte as command, empty parameter list, then an ignored byte
    send_byte(8'hff, 1'b1);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h41, 1'b0);
    // zero inside the nick
    send_byte(CH_COLON, 1'b1);
    send_byte(CH_NUL, 1'b0);
    // cr inside the command is ordinary, zero ends the line
    send_byte(8'h71, 1'b1);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_NUL, 1'b0);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) send_line();
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("irc_line_tokenizer verification clean");
    end else begin
      $display("irc_line_tokenizer verification failed");
    end
    $finish;
  end
endmodule
